[sv/srp_pkg.sv]
// Shared types, constants and command codes of the skyline rectangle placer.
// No dependencies.
package srp_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;
    localparam int CFG_IDX_BITS     = 4;
    localparam int OP_BITS          = 5;

    localparam logic [CFG_IDX_BITS-1:0] REG_BIN_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIN_HEIGHT = 4'd1;

    localparam logic [31:0] BIN_RESET = 32'd1024;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [OP_BITS-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_BITS-1:0] OP_TAKE      = 5'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR     = 5'd2;
    localparam logic [OP_BITS-1:0] OP_RES_NOFIT = 5'd3;
    localparam logic [OP_BITS-1:0] OP_RES_FULL  = 5'd4;
    localparam logic [OP_BITS-1:0] OP_OINIT     = 5'd5;
    localparam logic [OP_BITS-1:0] OP_CX_ZERO   = 5'd6;
    localparam logic [OP_BITS-1:0] OP_RD_CX     = 5'd7;
    localparam logic [OP_BITS-1:0] OP_CX_LOAD   = 5'd8;
    localparam logic [OP_BITS-1:0] OP_IINIT     = 5'd9;
    localparam logic [OP_BITS-1:0] OP_RD_I      = 5'd10;
    localparam logic [OP_BITS-1:0] OP_IDAT      = 5'd11;
    localparam logic [OP_BITS-1:0] OP_IACC      = 5'd12;
    localparam logic [OP_BITS-1:0] OP_WMUL      = 5'd13;
    localparam logic [OP_BITS-1:0] OP_WCMP      = 5'd14;
    localparam logic [OP_BITS-1:0] OP_JINIT     = 5'd15;
    localparam logic [OP_BITS-1:0] OP_RD_J      = 5'd16;
    localparam logic [OP_BITS-1:0] OP_JSTEP     = 5'd17;
    localparam logic [OP_BITS-1:0] OP_MINIT     = 5'd18;
    localparam logic [OP_BITS-1:0] OP_RD_M      = 5'd19;
    localparam logic [OP_BITS-1:0] OP_WR_M      = 5'd20;
    localparam logic [OP_BITS-1:0] OP_PUT       = 5'd21;
    localparam logic [OP_BITS-1:0] OP_LOAD_OUT  = 5'd22;

    typedef struct packed {
        logic        mode;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic        placed;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic w_zero;
        logic l_ge_cnt;
        logic l_zero;
        logic end_gt_bin;
        logic i_ge_cnt;
        logic reached;
        logic j_ge_cnt;
        logic j_le;
        logic found;
        logic k_zero;
        logic cnt_full;
        logic m_last;
    } sts_t;

endpackage

[sv/srp_datapath.sv]
// Datapath of the skyline placer: segment memory, scan counters, waste arithmetic,
// configuration and result registers. Depends on srp_pkg.
module srp_datapath #(
    parameter int MAX_SEGMENTS = srp_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = srp_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  srp_pkg::cmd_t                   cmd,
    output srp_pkg::sts_t                   sts,
    input  srp_pkg::in_item_t               s_data,
    input  logic                            cfg_valid,
    input  logic [srp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    output srp_pkg::out_item_t              m_data
);
    localparam int CW   = COORD_BITS;
    localparam int SEGB = $clog2(MAX_SEGMENTS);
    localparam int CNTB = $clog2(MAX_SEGMENTS + 1);
    localparam int AW   = 2 * CW + SEGB;
    localparam logic [CW-1:0] BIN_RESET_W = srp_pkg::BIN_RESET[CW-1:0];

    logic [CW-1:0] mem_right [MAX_SEGMENTS];
    logic [CW-1:0] mem_height [MAX_SEGMENTS];

    logic [CW-1:0]   bin_w_reg, bin_h_reg;
    logic [CNTB-1:0] cnt_reg, cnt_next;
    logic            mode_reg, mode_next;
    logic [CW-1:0]   w_reg, w_next, h_reg, h_next;
    logic [CNTB-1:0] l_reg, l_next, i_reg, i_next, j_reg, j_next;
    logic [CNTB-1:0] src_reg, src_next, dst_reg, dst_next, best_l_reg, best_l_next;
    logic            fwd_reg, fwd_next, reach_reg, reach_next, found_reg, found_next;
    logic [CW-1:0]   cx_reg, cx_next, prev_reg, prev_next, maxh_reg, maxh_next;
    logic [CW-1:0]   best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [2*CW-1:0] prod_reg, prod_next;
    logic [AW-1:0]   area_reg, area_next, best_waste_reg, best_waste_next;
    logic            res_placed_reg, res_placed_next;
    logic [CW-1:0]   res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [1:0]      res_status_reg, res_status_next;
    srp_pkg::out_item_t m_data_reg, m_data_next;

    logic [CW-1:0]   rd_right_reg, rd_height_reg;
    logic [SEGB-1:0] rd_addr, wr_addr;
    logic            wr_en;
    logic [CW-1:0]   wr_right, wr_height;

    logic [31:0]     cfg_ext, w_ext, h_ext, x_ext, y_ext;
    logic [CW:0]     end_w, best_end, fit_h;
    logic [CW-1:0]   seg_span, top_y;
    logic [AW-1:0]   waste;

    assign cfg_ext  = {16'b0, cfg_data};
    assign w_ext    = {16'b0, s_data.rect_width};
    assign h_ext    = {16'b0, s_data.rect_height};
    assign x_ext    = 32'(res_x_reg);
    assign y_ext    = 32'(res_y_reg);
    assign end_w    = {1'b0, cx_reg} + {1'b0, w_reg};
    assign best_end = {1'b0, best_x_reg} + {1'b0, w_reg};
    assign fit_h    = {1'b0, maxh_reg} + {1'b0, h_reg};
    assign seg_span = rd_right_reg - prev_reg;
    assign top_y    = best_y_reg + h_reg;
    assign waste    = AW'(prod_reg) - area_reg;

    assign sts.mode       = mode_reg;
    assign sts.w_zero     = (w_reg == '0);
    assign sts.l_ge_cnt   = (l_reg >= cnt_reg);
    assign sts.l_zero     = (l_reg == '0);
    assign sts.end_gt_bin = (end_w > {1'b0, bin_w_reg});
    assign sts.i_ge_cnt   = (i_reg >= cnt_reg);
    assign sts.reached    = reach_reg;
    assign sts.j_ge_cnt   = (j_reg >= cnt_reg);
    assign sts.j_le       = ({1'b0, rd_right_reg} <= best_end);
    assign sts.found      = found_reg;
    assign sts.k_zero     = (j_reg == best_l_reg);
    assign sts.cnt_full   = (cnt_reg >= CNTB'(MAX_SEGMENTS));
    assign sts.m_last     = fwd_reg ? ((src_reg + CNTB'(1)) == cnt_reg) : (src_reg == j_reg);

    always_comb begin
        case (cmd.op)
            srp_pkg::OP_RD_CX: rd_addr = SEGB'(l_reg - CNTB'(1));
            srp_pkg::OP_RD_I:  rd_addr = i_reg[SEGB-1:0];
            srp_pkg::OP_RD_J:  rd_addr = j_reg[SEGB-1:0];
            srp_pkg::OP_RD_M:  rd_addr = src_reg[SEGB-1:0];
            default:           rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_right  = rd_right_reg;
        wr_height = rd_height_reg;
        case (cmd.op)
            srp_pkg::OP_CLEAR: begin
                wr_en     = 1'b1;
                wr_right  = bin_w_reg;
                wr_height = '0;
            end
            srp_pkg::OP_WR_M: begin
                wr_en   = 1'b1;
                wr_addr = dst_reg[SEGB-1:0];
            end
            srp_pkg::OP_PUT: begin
                wr_en     = 1'b1;
                wr_addr   = best_l_reg[SEGB-1:0];
                wr_right  = best_end[CW-1:0];
                wr_height = top_y;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_right[wr_addr]  <= wr_right;
            mem_height[wr_addr] <= wr_height;
        end
        rd_right_reg  <= mem_right[rd_addr];
        rd_height_reg <= mem_height[rd_addr];
    end

    always_comb begin
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        l_next          = l_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        best_l_next     = best_l_reg;
        fwd_next        = fwd_reg;
        reach_next      = reach_reg;
        found_next      = found_reg;
        cx_next         = cx_reg;
        prev_next       = prev_reg;
        maxh_next       = maxh_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        prod_next       = prod_reg;
        area_next       = area_reg;
        best_waste_next = best_waste_reg;
        res_placed_next = res_placed_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_status_next = res_status_reg;
        m_data_next     = m_data_reg;
        case (cmd.op)
            srp_pkg::OP_TAKE: begin
                mode_next = s_data.mode;
                w_next    = w_ext[CW-1:0];
                h_next    = h_ext[CW-1:0];
            end
            srp_pkg::OP_CLEAR: begin
                cnt_next        = CNTB'(1);
                res_placed_next = 1'b0;
                res_x_next      = '0;
                res_y_next      = '0;
                res_status_next = srp_pkg::STATUS_OK;
            end
            srp_pkg::OP_RES_NOFIT: begin
                res_placed_next = 1'b0;
                res_x_next      = '0;
                res_y_next      = '0;
                res_status_next = srp_pkg::STATUS_NOFIT;
            end
            srp_pkg::OP_RES_FULL: begin
                res_placed_next = 1'b0;
                res_x_next      = '0;
                res_y_next      = '0;
                res_status_next = srp_pkg::STATUS_FULL;
            end
            srp_pkg::OP_OINIT: begin
                l_next     = '0;
                found_next = 1'b0;
            end
            srp_pkg::OP_CX_ZERO: begin
                cx_next = '0;
            end
            srp_pkg::OP_CX_LOAD: begin
                cx_next = rd_right_reg;
            end
            srp_pkg::OP_IINIT: begin
                i_next    = l_reg;
                maxh_next = '0;
                area_next = '0;
                prev_next = cx_reg;
            end
            srp_pkg::OP_IDAT: begin
                if (rd_height_reg > maxh_reg) begin
                    maxh_next = rd_height_reg;
                end
                prod_next  = rd_height_reg * seg_span;
                prev_next  = rd_right_reg;
                reach_next = ({1'b0, rd_right_reg} >= end_w);
            end
            srp_pkg::OP_IACC: begin
                area_next = area_reg + AW'(prod_reg);
                i_next    = i_reg + CNTB'(1);
            end
            srp_pkg::OP_WMUL: begin
                prod_next = maxh_reg * (prev_reg - cx_reg);
            end
            srp_pkg::OP_WCMP: begin
                if (fit_h <= {1'b0, bin_h_reg} && (!found_reg || waste < best_waste_reg)) begin
                    found_next      = 1'b1;
                    best_waste_next = waste;
                    best_l_next     = l_reg;
                    best_x_next     = cx_reg;
                    best_y_next     = maxh_reg;
                end
                l_next = l_reg + CNTB'(1);
            end
            srp_pkg::OP_JINIT: begin
                j_next = best_l_reg;
            end
            srp_pkg::OP_JSTEP: begin
                if ({1'b0, rd_right_reg} <= best_end) begin
                    j_next = j_reg + CNTB'(1);
                end
            end
            srp_pkg::OP_MINIT: begin
                fwd_next = (j_reg != best_l_reg);
                if (j_reg != best_l_reg) begin
                    src_next = j_reg;
                    dst_next = best_l_reg + CNTB'(1);
                end else begin
                    src_next = cnt_reg - CNTB'(1);
                    dst_next = cnt_reg;
                end
            end
            srp_pkg::OP_WR_M: begin
                if (fwd_reg) begin
                    src_next = src_reg + CNTB'(1);
                    dst_next = dst_reg + CNTB'(1);
                end else begin
                    src_next = src_reg - CNTB'(1);
                    dst_next = dst_reg - CNTB'(1);
                end
            end
            srp_pkg::OP_PUT: begin
                cnt_next        = cnt_reg - j_reg + best_l_reg + CNTB'(1);
                res_placed_next = 1'b1;
                res_x_next      = best_x_reg;
                res_y_next      = best_y_reg;
                res_status_next = srp_pkg::STATUS_OK;
            end
            srp_pkg::OP_LOAD_OUT: begin
                m_data_next.placed   = res_placed_reg;
                m_data_next.x_pos    = x_ext[15:0];
                m_data_next.y_pos    = y_ext[15:0];
                m_data_next.status   = res_status_reg;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_w_reg <= BIN_RESET_W;
            bin_h_reg <= BIN_RESET_W;
            cnt_reg   <= CNTB'(1);
        end else begin
            if (cfg_valid && cfg_index == srp_pkg::REG_BIN_WIDTH) begin
                bin_w_reg <= cfg_ext[CW-1:0];
            end
            if (cfg_valid && cfg_index == srp_pkg::REG_BIN_HEIGHT) begin
                bin_h_reg <= cfg_ext[CW-1:0];
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        l_reg          <= l_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        best_l_reg     <= best_l_next;
        fwd_reg        <= fwd_next;
        reach_reg      <= reach_next;
        found_reg      <= found_next;
        cx_reg         <= cx_next;
        prev_reg       <= prev_next;
        maxh_reg       <= maxh_next;
        best_x_reg     <= best_x_next;
        best_y_reg     <= best_y_next;
        prod_reg       <= prod_next;
        area_reg       <= area_next;
        best_waste_reg <= best_waste_next;
        res_placed_reg <= res_placed_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_data = m_data_reg;

endmodule

[sv/srp_controller.sv]
// Sequencer of the skyline placer: steps the datapath through scan, shift and update.
// Owns the input and result handshakes. Depends on srp_pkg.
module srp_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output srp_pkg::cmd_t cmd,
    input  srp_pkg::sts_t sts
);
    localparam logic [4:0] ST_INIT   = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_DISP   = 5'd2;
    localparam logic [4:0] ST_CLR    = 5'd3;
    localparam logic [4:0] ST_FAIL   = 5'd4;
    localparam logic [4:0] ST_OINIT  = 5'd5;
    localparam logic [4:0] ST_OTOP   = 5'd6;
    localparam logic [4:0] ST_OCX    = 5'd7;
    localparam logic [4:0] ST_OCHK   = 5'd8;
    localparam logic [4:0] ST_IRD    = 5'd9;
    localparam logic [4:0] ST_IDAT   = 5'd10;
    localparam logic [4:0] ST_IACC   = 5'd11;
    localparam logic [4:0] ST_WMUL   = 5'd12;
    localparam logic [4:0] ST_WCMP   = 5'd13;
    localparam logic [4:0] ST_DECIDE = 5'd14;
    localparam logic [4:0] ST_JRD    = 5'd15;
    localparam logic [4:0] ST_JDAT   = 5'd16;
    localparam logic [4:0] ST_JCHK   = 5'd17;
    localparam logic [4:0] ST_MRD    = 5'd18;
    localparam logic [4:0] ST_MWR    = 5'd19;
    localparam logic [4:0] ST_PUT    = 5'd20;
    localparam logic [4:0] ST_DONE   = 5'd21;

    logic [4:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.op     = srp_pkg::OP_NONE;
        case (state_reg)
            ST_INIT: begin
                cmd.op     = srp_pkg::OP_CLEAR;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = srp_pkg::OP_TAKE;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (!sts.mode) begin
                    state_next = ST_CLR;
                end else if (sts.w_zero) begin
                    state_next = ST_FAIL;
                end else begin
                    state_next = ST_OINIT;
                end
            end
            ST_CLR: begin
                cmd.op     = srp_pkg::OP_CLEAR;
                state_next = ST_DONE;
            end
            ST_FAIL: begin
                cmd.op     = srp_pkg::OP_RES_NOFIT;
                state_next = ST_DONE;
            end
            ST_OINIT: begin
                cmd.op     = srp_pkg::OP_OINIT;
                state_next = ST_OTOP;
            end
            ST_OTOP: begin
                if (sts.l_ge_cnt) begin
                    state_next = ST_DECIDE;
                end else if (sts.l_zero) begin
                    cmd.op     = srp_pkg::OP_CX_ZERO;
                    state_next = ST_OCHK;
                end else begin
                    cmd.op     = srp_pkg::OP_RD_CX;
                    state_next = ST_OCX;
                end
            end
            ST_OCX: begin
                cmd.op     = srp_pkg::OP_CX_LOAD;
                state_next = ST_OCHK;
            end
            ST_OCHK: begin
                if (sts.end_gt_bin) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.op     = srp_pkg::OP_IINIT;
                    state_next = ST_IRD;
                end
            end
            ST_IRD: begin
                if (sts.i_ge_cnt) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.op     = srp_pkg::OP_RD_I;
                    state_next = ST_IDAT;
                end
            end
            ST_IDAT: begin
                cmd.op     = srp_pkg::OP_IDAT;
                state_next = ST_IACC;
            end
            ST_IACC: begin
                cmd.op     = srp_pkg::OP_IACC;
                state_next = sts.reached ? ST_WMUL : ST_IRD;
            end
            ST_WMUL: begin
                cmd.op     = srp_pkg::OP_WMUL;
                state_next = ST_WCMP;
            end
            ST_WCMP: begin
                cmd.op     = srp_pkg::OP_WCMP;
                state_next = ST_OTOP;
            end
            ST_DECIDE: begin
                if (!sts.found) begin
                    cmd.op     = srp_pkg::OP_RES_NOFIT;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = srp_pkg::OP_JINIT;
                    state_next = ST_JRD;
                end
            end
            ST_JRD: begin
                if (sts.j_ge_cnt) begin
                    state_next = ST_JCHK;
                end else begin
                    cmd.op     = srp_pkg::OP_RD_J;
                    state_next = ST_JDAT;
                end
            end
            ST_JDAT: begin
                cmd.op     = srp_pkg::OP_JSTEP;
                state_next = sts.j_le ? ST_JRD : ST_JCHK;
            end
            ST_JCHK: begin
                if (sts.k_zero && sts.cnt_full) begin
                    cmd.op     = srp_pkg::OP_RES_FULL;
                    state_next = ST_DONE;
                end else if (!sts.j_ge_cnt) begin
                    cmd.op     = srp_pkg::OP_MINIT;
                    state_next = ST_MRD;
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_MRD: begin
                cmd.op     = srp_pkg::OP_RD_M;
                state_next = ST_MWR;
            end
            ST_MWR: begin
                cmd.op     = srp_pkg::OP_WR_M;
                state_next = sts.m_last ? ST_PUT : ST_MRD;
            end
            ST_PUT: begin
                cmd.op     = srp_pkg::OP_PUT;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.op     = srp_pkg::OP_LOAD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[sv/skyline_rect_placer_unit.sv]
// Top level of the skyline rectangle placer: controller plus datapath.
// Depends on srp_pkg, srp_controller and srp_datapath.
//
// Input channel s_valid/s_ready/s_data carries one item: mode 0 clears the
// skyline to one flat segment of bin_width, mode 1 places a rectangle.
// Each item gives one result on m_valid/m_ready/m_data: placed, x_pos, y_pos
// and status (ok, no fitting position, segment store full).
// Configuration cfg_valid/cfg_ready/cfg_index/cfg_data writes bin_width
// (index 0) and bin_height (index 1); cfg_ready is always high.
// Items are taken one at a time. A place item first scans the tried left edges
// over the segments that each covers, then searches for the cut and moves
// segments; the segment memory has a single read port.
// After reset the flat segment is written, during which s_ready is low.
// The finished result sits in an output register; while the receiver stalls
// the next item is taken and worked on, and its result waits until the
// register frees.
module skyline_rect_placer_unit #(
    parameter int MAX_SEGMENTS = srp_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = srp_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  srp_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output srp_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    srp_pkg::cmd_t cmd;
    srp_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    srp_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    srp_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

    a_take_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded without return to idle");

    a_reset_init: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during initial clear");

    a_take_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (cmd.op == srp_pkg::OP_TAKE))
        else $error("accepted item not latched");

endmodule
